[design/lrb_pkg.sv]
// Shared types and constants of the link reconnect backoff controller.
package lrb_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned JIT_W   = 16;
	localparam int unsigned REM_W   = JIT_W + 1;
	localparam int unsigned BIT_W   = $clog2(TIME_W);
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned IN_W    = 72;
	localparam int unsigned OUT_W   = 48;

	// Link state codes as seen on the result word.
	localparam logic [1:0] LS_IDLE       = 2'd0;
	localparam logic [1:0] LS_CONNECTING = 2'd1;
	localparam logic [1:0] LS_BACKOFF    = 2'd2;
	localparam logic [1:0] LS_CONNECTED  = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE       = 4'b0001,
		ST_CONNECTING = 4'b0010,
		ST_BACKOFF    = 4'b0100,
		ST_CONNECTED  = 4'b1000
	} link_fsm_t;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_INIT_BACKOFF = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_BACKOFF  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAST_RETRIES = 3'd2;
	localparam logic [IDX_W-1:0] REG_JITTER       = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_UPTIME   = 3'd4;
	localparam logic [IDX_W-1:0] REG_CONN_TIMEOUT = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd6;
	localparam logic [IDX_W-1:0] REG_SSID_PRESENT = 3'd7;

	// Register values after reset.
	localparam logic [TIME_W-1:0] INIT_BACKOFF_RST = 32'd1000;
	localparam logic [TIME_W-1:0] MAX_BACKOFF_RST  = 32'd60000;
	localparam logic [CNT_W-1:0]  FAST_RETRIES_RST = 8'd5;
	localparam logic [JIT_W-1:0]  JITTER_RST       = 16'd0;
	localparam logic [TIME_W-1:0] MIN_UPTIME_RST   = 32'd10000;
	localparam logic [TIME_W-1:0] CONN_TIMEOUT_RST = 32'd5000;
	localparam logic [JIT_W-1:0]  DEBOUNCE_RST     = 16'd2000;

	// Load and step strobes for the serial units.
	typedef struct packed {
		logic load;
		logic step;
	} seq_ctl_t;

	// Sequencer phases of one word.
	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_A    = 5'b00010,
		PH_MID  = 5'b00100,
		PH_B    = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

endpackage

[design/lrb_serial_add.sv]
// One-bit serial adder/subtractor cell with its carry flop, LSB first.
module lrb_serial_add (
	input  logic              clk,
	input  logic              arst_n,
	input  lrb_pkg::seq_ctl_t ctl,
	input  logic              sub,
	input  logic              a,
	input  logic              b,
	output logic              s,
	output logic              cy
);

	logic cy_q;
	logic bb;

	assign bb = b ^ sub;
	assign s  = a ^ bb ^ cy_q;
	assign cy = cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= 1'b0;
		end else if (ctl.load) begin
			cy_q <= sub;
		end else if (ctl.step) begin
			cy_q <= (a & bb) | (a & cy_q) | (bb & cy_q);
		end
	end

endmodule

[design/lrb_backoff.sv]
// Doubling sequencer for the retry delay: one doubling per cycle while stepped, capped.
module lrb_backoff (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lrb_pkg::seq_ctl_t                ctl,
	input  logic [lrb_pkg::TIME_W-1:0]       init_ms,
	input  logic [lrb_pkg::TIME_W-1:0]       max_ms,
	input  logic [lrb_pkg::CNT_W-1:0]        doublings,
	output logic [lrb_pkg::TIME_W-1:0]       base_ms
);

	logic [lrb_pkg::TIME_W-1:0] base_q;
	logic [lrb_pkg::CNT_W-1:0]  left_q;
	logic                       done_q;
	logic [lrb_pkg::TIME_W-1:0] half;

	assign half    = max_ms >> 1;
	assign base_ms = (base_q > max_ms) ? max_ms : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			done_q <= 1'b0;
		end else if (ctl.load) begin
			left_q <= doublings;
			done_q <= 1'b0;
		end else if (ctl.step && left_q != '0 && !done_q) begin
			if (base_q > half) begin
				done_q <= 1'b1;
			end else begin
				left_q <= left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= init_ms;
		end else if (ctl.step && left_q != '0 && !done_q) begin
			if (base_q > half) begin
				base_q <= max_ms;
			end else begin
				base_q <= {base_q[lrb_pkg::TIME_W-2:0], 1'b0};
			end
		end
	end

endmodule

[design/lrb_jitter_div.sv]
// Restoring serial divider: remainder of the random word by jitter + 1.
module lrb_jitter_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lrb_pkg::seq_ctl_t          ctl,
	input  logic [lrb_pkg::TIME_W-1:0] rnd,
	input  logic [lrb_pkg::JIT_W-1:0]  jitter_ms,
	output logic [lrb_pkg::REM_W-1:0]  rem
);

	logic [lrb_pkg::TIME_W-1:0] num_q;
	logic [lrb_pkg::REM_W-1:0]  rem_q;
	logic [lrb_pkg::REM_W:0]    part;
	logic [lrb_pkg::REM_W:0]    dvs;

	assign part = {rem_q, num_q[lrb_pkg::TIME_W-1]};
	assign dvs  = {2'b00, jitter_ms} + {{lrb_pkg::REM_W{1'b0}}, 1'b1};
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= '0;
		end else if (ctl.step) begin
			if (part >= dvs) begin
				rem_q <= lrb_pkg::REM_W'(part - dvs);
			end else begin
				rem_q <= part[lrb_pkg::REM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= rnd;
		end else if (ctl.step) begin
			num_q <= {num_q[lrb_pkg::TIME_W-2:0], 1'b0};
		end
	end

endmodule

[design/link_reconnect_backoff_fsm.sv]
// Link reconnect controller with exponential retry backoff, bit-serial datapath.
//
// Each input word is a poll or a start request (s_tuser) with the millisecond
// time, link-up and association flags and a random word; each produces exactly
// one result word. The block works on one word at a time: the next word is
// accepted only after the result of the last one is loaded. Each word runs
// two 32-bit serial passes over the time fields, one bit per cycle: pass A
// runs all deadline, uptime and debounce compares and the connect timeout sum
// in parallel serial cells, while the doubling sequencer and the jitter divider
// take one step per cycle alongside; a middle phase picks up the capped delay
// and the remainder; pass B forms delay and next deadline serially; a final
// phase updates the state and loads the output register.
// The result register lets the next word be accepted while a result waits.
// The config port always accepts; write it only while no word is in flight.
module link_reconnect_backoff_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrb_pkg::IDX_W-1:0]     cfg_index,
	input  logic [lrb_pkg::TIME_W-1:0]    cfg_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] now_ms, [32] link_up, [33] assoc_up, [65:34] random_word, rest zero
	input  logic [lrb_pkg::IN_W-1:0]      s_tdata,
	// [0] func
	input  logic                          s_tuser,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] link_state, [9:2] attempt_count, [10] connect_pulse,
	// [42:11] retry_delay_ms, [43] link_ready, [44] upper_clear_pulse,
	// [45] flapping, [46] name_missing, [47] zero
	output logic [lrb_pkg::OUT_W-1:0]     m_tdata
);

	localparam int unsigned TW = lrb_pkg::TIME_W;

	// configuration registers
	logic [TW-1:0]               init_backoff_q;
	logic [TW-1:0]               max_backoff_q;
	logic [lrb_pkg::CNT_W-1:0]   fast_retries_q;
	logic [lrb_pkg::JIT_W-1:0]   jitter_q;
	logic [TW-1:0]               min_uptime_q;
	logic [TW-1:0]               conn_timeout_q;
	logic [lrb_pkg::JIT_W-1:0]   debounce_q;
	logic                        ssid_q;

	// controller state
	lrb_pkg::link_fsm_t          fsm_q;
	logic [lrb_pkg::CNT_W-1:0]   attempts_q;
	logic [TW-1:0]               next_action_q;
	logic [TW-1:0]               connected_at_q;
	logic [TW-1:0]               lost_since_q;
	logic                        ready_q;
	logic [TW-1:0]               retry_delay_q;

	// sequencer and per-word registers
	lrb_pkg::phase_t             phase_q;
	logic [lrb_pkg::BIT_W-1:0]   bit_q;
	logic                        func_q;
	logic                        link_q;
	logic                        assoc_q;
	logic [lrb_pkg::CNT_W-1:0]   att_new_q;
	logic [TW-1:0]               now_q;
	logic [TW-1:0]               to_sum_q;
	logic [TW-1:0]               base_q;
	logic [TW-1:0]               rem_q;
	logic [TW-1:0]               delay_q;
	logic [TW-1:0]               nxt_q;
	logic                        next_nz_q;
	logic                        lost_nz_q;

	// output register
	logic                        m_tvalid_q;
	logic [lrb_pkg::OUT_W-1:0]   m_tdata_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        finish;
	logic                        run_a;
	logic                        run_b;
	logic                        last_bit;
	logic                        deb_bit;
	logic [lrb_pkg::CNT_W-1:0]   att_inc;
	logic [lrb_pkg::CNT_W-1:0]   doublings;
	lrb_pkg::seq_ctl_t           ctl_a;
	lrb_pkg::seq_ctl_t           ctl_b;

	logic [TW-1:0]               base_ms;
	logic [lrb_pkg::REM_W-1:0]   rem_ms;

	logic s_ge, cy_ge;
	logic s_dl, cy_dl;
	logic s_dlc, cy_dlc;
	logic s_du, cy_du;
	logic s_duc, cy_duc;
	logic s_to, cy_to;
	logic s_d1, cy_d1;
	logic s_d2, cy_d2;

	// next-state values of the final cycle
	lrb_pkg::link_fsm_t          nx_state;
	logic [1:0]                  nx_code;
	logic [lrb_pkg::CNT_W-1:0]   nx_att;
	logic [TW-1:0]               nx_next;
	logic [TW-1:0]               nx_conn;
	logic [TW-1:0]               nx_lost;
	logic                        nx_ready;
	logic [TW-1:0]               nx_delay;
	logic                        o_conn;
	logic                        o_clear;
	logic                        o_flap;
	logic                        o_miss;
	logic                        do_try;
	logic                        do_retry;
	logic                        hold;

	assign cfg_ready = 1'b1;
	assign s_tready  = (phase_q == lrb_pkg::PH_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish    = (phase_q == lrb_pkg::PH_DONE) && out_free;
	assign run_a     = (phase_q == lrb_pkg::PH_A);
	assign run_b     = (phase_q == lrb_pkg::PH_B);
	assign last_bit  = (bit_q == lrb_pkg::BIT_W'(TW - 1));
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// debounce is 16 bits: feed zeros in the upper half of the pass
	assign deb_bit = !bit_q[lrb_pkg::BIT_W-1] && debounce_q[0];

	assign att_inc   = (attempts_q == '1) ? attempts_q : attempts_q + 1'b1;
	assign doublings = (att_inc <= fast_retries_q) ? att_inc : fast_retries_q;

	assign ctl_a.load = in_acc;
	assign ctl_a.step = run_a;
	assign ctl_b.load = in_acc;
	assign ctl_b.step = run_b;

	// ---- config writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_backoff_q <= lrb_pkg::INIT_BACKOFF_RST;
			max_backoff_q  <= lrb_pkg::MAX_BACKOFF_RST;
			fast_retries_q <= lrb_pkg::FAST_RETRIES_RST;
			jitter_q       <= lrb_pkg::JITTER_RST;
			min_uptime_q   <= lrb_pkg::MIN_UPTIME_RST;
			conn_timeout_q <= lrb_pkg::CONN_TIMEOUT_RST;
			debounce_q     <= lrb_pkg::DEBOUNCE_RST;
			ssid_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrb_pkg::REG_INIT_BACKOFF: init_backoff_q <= cfg_data;
				lrb_pkg::REG_MAX_BACKOFF:  max_backoff_q  <= cfg_data;
				lrb_pkg::REG_FAST_RETRIES: fast_retries_q <= cfg_data[lrb_pkg::CNT_W-1:0];
				lrb_pkg::REG_JITTER:       jitter_q       <= cfg_data[lrb_pkg::JIT_W-1:0];
				lrb_pkg::REG_MIN_UPTIME:   min_uptime_q   <= cfg_data;
				lrb_pkg::REG_CONN_TIMEOUT: conn_timeout_q <= cfg_data;
				lrb_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_data[lrb_pkg::JIT_W-1:0];
				lrb_pkg::REG_SSID_PRESENT: ssid_q         <= cfg_data[0];
			endcase
		end else if (run_a) begin
			// rotate operands through the serial cells; a full pass restores them
			min_uptime_q   <= {min_uptime_q[0], min_uptime_q[TW-1:1]};
			conn_timeout_q <= {conn_timeout_q[0], conn_timeout_q[TW-1:1]};
			if (!bit_q[lrb_pkg::BIT_W-1]) begin
				debounce_q <= {debounce_q[0], debounce_q[lrb_pkg::JIT_W-1:1]};
			end
		end
	end

	// ---- serial cells, pass A ----
	// now >= next deadline
	lrb_serial_add u_ge (.clk, .arst_n, .ctl(ctl_a), .sub(1'b1),
		.a(now_q[0]), .b(next_action_q[0]), .s(s_ge), .cy(cy_ge));
	// now - lost_since, then compared against debounce
	lrb_serial_add u_dl (.clk, .arst_n, .ctl(ctl_a), .sub(1'b1),
		.a(now_q[0]), .b(lost_since_q[0]), .s(s_dl), .cy(cy_dl));
	lrb_serial_add u_dlc (.clk, .arst_n, .ctl(ctl_a), .sub(1'b1),
		.a(s_dl), .b(deb_bit), .s(s_dlc), .cy(cy_dlc));
	// uptime, then compared against min uptime
	lrb_serial_add u_du (.clk, .arst_n, .ctl(ctl_a), .sub(1'b1),
		.a(now_q[0]), .b(connected_at_q[0]), .s(s_du), .cy(cy_du));
	lrb_serial_add u_duc (.clk, .arst_n, .ctl(ctl_a), .sub(1'b1),
		.a(s_du), .b(min_uptime_q[0]), .s(s_duc), .cy(cy_duc));
	// connect deadline
	lrb_serial_add u_to (.clk, .arst_n, .ctl(ctl_a), .sub(1'b0),
		.a(now_q[0]), .b(conn_timeout_q[0]), .s(s_to), .cy(cy_to));

	// ---- serial cells, pass B ----
	// delay = capped base + jitter, deadline = now + delay
	lrb_serial_add u_d1 (.clk, .arst_n, .ctl(ctl_b), .sub(1'b0),
		.a(base_q[0]), .b(rem_q[0]), .s(s_d1), .cy(cy_d1));
	lrb_serial_add u_d2 (.clk, .arst_n, .ctl(ctl_b), .sub(1'b0),
		.a(now_q[0]), .b(s_d1), .s(s_d2), .cy(cy_d2));

	lrb_backoff u_backoff (
		.clk, .arst_n, .ctl(ctl_a),
		.init_ms(init_backoff_q), .max_ms(max_backoff_q),
		.doublings(doublings), .base_ms(base_ms)
	);

	lrb_jitter_div u_jdiv (
		.clk, .arst_n, .ctl(ctl_a),
		.rnd(s_tdata[65:34]), .jitter_ms(jitter_q), .rem(rem_ms)
	);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrb_pkg::PH_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (phase_q)
				lrb_pkg::PH_IDLE: begin
					bit_q <= '0;
					if (in_acc) begin
						phase_q <= lrb_pkg::PH_A;
					end
				end
				lrb_pkg::PH_A: begin
					bit_q <= bit_q + 1'b1;
					if (last_bit) begin
						phase_q <= lrb_pkg::PH_MID;
					end
				end
				lrb_pkg::PH_MID: begin
					bit_q   <= '0;
					phase_q <= lrb_pkg::PH_B;
				end
				lrb_pkg::PH_B: begin
					bit_q <= bit_q + 1'b1;
					if (last_bit) begin
						phase_q <= lrb_pkg::PH_DONE;
					end
				end
				lrb_pkg::PH_DONE: begin
					if (out_free) begin
						phase_q <= lrb_pkg::PH_IDLE;
					end
				end
				default: phase_q <= lrb_pkg::PH_IDLE;
			endcase
		end
	end

	// ---- per-word datapath registers ----
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q    <= s_tuser;
			link_q    <= s_tdata[32];
			assoc_q   <= s_tdata[33];
			now_q     <= s_tdata[31:0];
			att_new_q <= att_inc;
			next_nz_q <= 1'b0;
			lost_nz_q <= 1'b0;
		end else if (run_a) begin
			now_q     <= {now_q[0], now_q[TW-1:1]};
			to_sum_q  <= {s_to, to_sum_q[TW-1:1]};
			next_nz_q <= next_nz_q | next_action_q[0];
			lost_nz_q <= lost_nz_q | lost_since_q[0];
		end else if (phase_q == lrb_pkg::PH_MID) begin
			// pick up the capped base and the jitter remainder
			base_q <= base_ms;
			rem_q  <= {{(TW - lrb_pkg::REM_W){1'b0}}, rem_ms};
		end else if (run_b) begin
			now_q   <= {now_q[0], now_q[TW-1:1]};
			base_q  <= {1'b0, base_q[TW-1:1]};
			rem_q   <= {1'b0, rem_q[TW-1:1]};
			delay_q <= {s_d1, delay_q[TW-1:1]};
			nxt_q   <= {s_d2, nxt_q[TW-1:1]};
		end
	end

	// ---- decision of the final cycle ----
	always_comb begin
		nx_state = fsm_q;
		nx_code  = lrb_pkg::LS_IDLE;
		nx_att   = attempts_q;
		nx_next  = next_action_q;
		nx_conn  = connected_at_q;
		nx_lost  = lost_since_q;
		nx_ready = ready_q;
		nx_delay = retry_delay_q;
		o_conn   = 1'b0;
		o_clear  = 1'b0;
		o_flap   = 1'b0;
		o_miss   = 1'b0;
		do_try   = 1'b0;
		do_retry = 1'b0;
		hold     = 1'b0;

		if (func_q) begin
			// start request: drop all progress, then try to connect
			nx_att   = '0;
			nx_ready = 1'b0;
			nx_state = lrb_pkg::ST_IDLE;
			nx_next  = '0;
			nx_lost  = '0;
			o_clear  = 1'b1;
			do_try   = 1'b1;
		end else begin
			unique case (fsm_q)
				lrb_pkg::ST_CONNECTING: begin
					if (link_q) begin
						nx_state = lrb_pkg::ST_CONNECTED;
						nx_conn  = now_q;
						nx_att   = '0;
						nx_ready = 1'b1;
					end else if (next_nz_q && cy_ge) begin
						// zero deadline means no timeout
						do_retry = 1'b1;
					end
				end
				lrb_pkg::ST_BACKOFF: begin
					if (cy_ge) begin
						do_try = 1'b1;
					end
				end
				lrb_pkg::ST_CONNECTED: begin
					if (debounce_q != '0) begin
						if (!assoc_q) begin
							// fresh loss starts the window at now, so it always holds
							if (!lost_nz_q) begin
								nx_lost = now_q;
							end
							hold = lost_nz_q ? !cy_dlc : 1'b1;
						end else begin
							nx_lost = '0;
						end
					end
					if (!hold && !link_q) begin
						o_flap   = !cy_duc;
						nx_ready = 1'b0;
						o_clear  = 1'b1;
						do_retry = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (do_try) begin
			if (!ssid_q) begin
				o_miss = 1'b1;
			end else begin
				nx_ready = 1'b0;
				o_clear  = 1'b1;
				o_conn   = 1'b1;
				nx_state = lrb_pkg::ST_CONNECTING;
				nx_next  = to_sum_q;
			end
		end

		if (do_retry) begin
			nx_att   = att_new_q;
			nx_delay = delay_q;
			nx_next  = nxt_q;
			nx_state = lrb_pkg::ST_BACKOFF;
		end

		// map the state onto the link state code of the result word
		unique case (nx_state)
			lrb_pkg::ST_IDLE:       nx_code = lrb_pkg::LS_IDLE;
			lrb_pkg::ST_CONNECTING: nx_code = lrb_pkg::LS_CONNECTING;
			lrb_pkg::ST_BACKOFF:    nx_code = lrb_pkg::LS_BACKOFF;
			lrb_pkg::ST_CONNECTED:  nx_code = lrb_pkg::LS_CONNECTED;
			default:                nx_code = lrb_pkg::LS_IDLE;
		endcase
	end

	// ---- controller state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q          <= lrb_pkg::ST_IDLE;
			attempts_q     <= '0;
			next_action_q  <= '0;
			connected_at_q <= '0;
			lost_since_q   <= '0;
			ready_q        <= 1'b0;
			retry_delay_q  <= '0;
		end else if (run_a) begin
			next_action_q  <= {next_action_q[0], next_action_q[TW-1:1]};
			connected_at_q <= {connected_at_q[0], connected_at_q[TW-1:1]};
			lost_since_q   <= {lost_since_q[0], lost_since_q[TW-1:1]};
		end else if (finish) begin
			fsm_q          <= nx_state;
			attempts_q     <= nx_att;
			next_action_q  <= nx_next;
			connected_at_q <= nx_conn;
			lost_since_q   <= nx_lost;
			ready_q        <= nx_ready;
			retry_delay_q  <= nx_delay;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {1'b0, o_miss, o_flap, o_clear, nx_ready, nx_delay,
				o_conn, nx_att, nx_code};
		end
	end

endmodule
